/* sv/trl_pkg.sv */
// ----------------------------------------------------------------------------
// trl_pkg
// Shared constants and types for the tunnel range lookup: table size,
// operation and status codes, and the stage record passed between stages.
// ----------------------------------------------------------------------------
package trl_pkg;

  // Table size and derived index width
  localparam int GROUPS = 16;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int SLOT_W = 4;
  localparam int ADDR_W = 32;
  localparam int ID_W   = 32;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER   = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERLAP = 2'd3;

  // Result of the table stage, handed to the tunnel ID arithmetic
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] offset;
    logic [ID_W-1:0]   step;
    logic [ID_W-1:0]   first;
  } match_t;

endpackage

/* sv/tunnel_range_lookup_teid.sv */
// ----------------------------------------------------------------------------
// tunnel_range_lookup_teid
// Address range table with per-range tunnel ID computation.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle while busy is low and gives its
// result as a one-cycle pulse on out_valid; results come back in order and
// cannot be held off. An item passes through the input register, the table
// stage (parallel range compare over all slots), the multiply stage and the
// final add into the result register. Clear and write take effect in the
// table stage, so an item accepted in the next cycle already sees them. busy
// is high only while reset is held.
module tunnel_range_lookup_teid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [trl_pkg::OP_W-1:0]      in_operation,
  input  logic [trl_pkg::SLOT_W-1:0]    in_entry_slot,
  input  logic [trl_pkg::ADDR_W-1:0]    in_lookup_address,
  input  logic [trl_pkg::ADDR_W-1:0]    in_range_start,
  input  logic [trl_pkg::ADDR_W-1:0]    in_range_end,
  input  logic [trl_pkg::ID_W-1:0]      in_initial_teid,
  input  logic [trl_pkg::ID_W-1:0]      in_teid_step,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [trl_pkg::SLOT_W-1:0]    out_group_slot,
  output logic [trl_pkg::ID_W-1:0]      out_tunnel_id,
  output logic [trl_pkg::STAT_W-1:0]    out_status
);

  logic                         in_vld_r;
  logic [trl_pkg::OP_W-1:0]     in_op_r;
  logic [trl_pkg::SLOT_W-1:0]   in_slot_r;
  logic [trl_pkg::ADDR_W-1:0]   in_addr_r;
  logic [trl_pkg::ADDR_W-1:0]   in_lo_r;
  logic [trl_pkg::ADDR_W-1:0]   in_hi_r;
  logic [trl_pkg::ID_W-1:0]     in_first_r;
  logic [trl_pkg::ID_W-1:0]     in_step_r;
  trl_pkg::match_t              match;

  assign busy = ~rst_n;

  // Capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_op_r    <= in_operation;
    in_slot_r  <= in_entry_slot;
    in_addr_r  <= in_lookup_address;
    in_lo_r    <= in_range_start;
    in_hi_r    <= in_range_end;
    in_first_r <= in_initial_teid;
    in_step_r  <= in_teid_step;
  end

  trl_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (in_vld_r),
    .req_op    (in_op_r),
    .req_slot  (in_slot_r),
    .req_addr  (in_addr_r),
    .req_lo    (in_lo_r),
    .req_hi    (in_hi_r),
    .req_first (in_first_r),
    .req_step  (in_step_r),
    .match_r   (match)
  );

  trl_teid_calc u_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .match_i        (match),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_group_slot (out_group_slot),
    .out_tunnel_id  (out_tunnel_id),
    .out_status     (out_status)
  );

  // Every accepted item yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted item produced no result");

  // A result only follows an accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted item");

  // A hit always reports ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == trl_pkg::ST_OK))
    else $error("hit with non-ok status");

  // Without a hit, slot and tunnel ID are zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_group_slot == '0 && out_tunnel_id == '0))
    else $error("nonzero slot or tunnel ID without a hit");

endmodule

/* sv/trl_table.sv */
// ----------------------------------------------------------------------------
// trl_table
// Range table storage with parallel range match and overlap check. Clears,
// writes and lookups all resolve here, so the next item always sees the
// table as this one left it.
// ----------------------------------------------------------------------------
module trl_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_vld,
  input  logic [trl_pkg::OP_W-1:0]      req_op,
  input  logic [trl_pkg::SLOT_W-1:0]    req_slot,
  input  logic [trl_pkg::ADDR_W-1:0]    req_addr,
  input  logic [trl_pkg::ADDR_W-1:0]    req_lo,
  input  logic [trl_pkg::ADDR_W-1:0]    req_hi,
  input  logic [trl_pkg::ID_W-1:0]      req_first,
  input  logic [trl_pkg::ID_W-1:0]      req_step,
  output trl_pkg::match_t               match_r
);

  logic [trl_pkg::GROUPS-1:0]   valid_r;
  logic [trl_pkg::GROUPS-1:0]   valid_nxt;
  logic [trl_pkg::ADDR_W-1:0]   start_r [trl_pkg::GROUPS];
  logic [trl_pkg::ADDR_W-1:0]   end_r   [trl_pkg::GROUPS];
  logic [trl_pkg::ID_W-1:0]     first_r [trl_pkg::GROUPS];
  logic [trl_pkg::ID_W-1:0]     step_r  [trl_pkg::GROUPS];

  logic [trl_pkg::GROUPS-1:0]   hits;
  logic [trl_pkg::GROUPS-1:0]   ovl;
  logic [trl_pkg::SLOT_W-1:0]   sel_slot;
  logic [trl_pkg::ADDR_W-1:0]   sel_start;
  logic [trl_pkg::ID_W-1:0]     sel_first;
  logic [trl_pkg::ID_W-1:0]     sel_step;
  logic [trl_pkg::GRP_W-1:0]    slot_idx;
  logic                         slot_ok;
  logic                         wr_en;
  trl_pkg::match_t              match_nxt;

  assign slot_idx = trl_pkg::GRP_W'(req_slot);
  assign slot_ok  = int'(req_slot) < trl_pkg::GROUPS;

  // Compare every valid entry against the address and the new range
  always_comb begin
    for (int i = 0; i < trl_pkg::GROUPS; i++) begin
      hits[i] = valid_r[i] && (start_r[i] <= req_addr) && (req_addr <= end_r[i]);
      ovl[i]  = valid_r[i] && (int'(req_slot) != i) &&
                (req_lo <= end_r[i]) && (start_r[i] <= req_hi);
    end
  end

  // Select the matching entry; valid ranges never overlap, so at most one hits
  always_comb begin
    sel_slot  = '0;
    sel_start = '0;
    sel_first = '0;
    sel_step  = '0;
    for (int i = 0; i < trl_pkg::GROUPS; i++) begin
      if (hits[i]) begin
        sel_slot  = sel_slot  | trl_pkg::SLOT_W'(i);
        sel_start = sel_start | start_r[i];
        sel_first = sel_first | first_r[i];
        sel_step  = sel_step  | step_r[i];
      end
    end
  end

  // Decode the operation into a table update and a stage record
  always_comb begin
    valid_nxt        = valid_r;
    wr_en            = 1'b0;
    match_nxt        = '0;
    match_nxt.vld    = req_vld;
    match_nxt.status = trl_pkg::ST_OK;
    if (req_vld) begin
      case (req_op)
        trl_pkg::OP_CLEAR: begin
          valid_nxt = '0;
        end
        trl_pkg::OP_WRITE: begin
          if (req_lo > req_hi) begin
            match_nxt.status = trl_pkg::ST_ORDER;
          end else if (slot_ok) begin
            if (|ovl) begin
              match_nxt.status = trl_pkg::ST_OVERLAP;
            end else begin
              wr_en               = 1'b1;
              valid_nxt[slot_idx] = 1'b1;
            end
          end
        end
        trl_pkg::OP_LOOKUP: begin
          if (|hits) begin
            match_nxt.hit    = 1'b1;
            match_nxt.slot   = sel_slot;
            match_nxt.offset = req_addr - sel_start;
            match_nxt.step   = sel_step;
            match_nxt.first  = sel_first;
          end else begin
            match_nxt.status = trl_pkg::ST_MISS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold valid bits and the stage record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      match_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  // Store an accepted entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_r[slot_idx] <= req_lo;
      end_r[slot_idx]   <= req_hi;
      first_r[slot_idx] <= req_first;
      step_r[slot_idx]  <= req_step;
    end
  end

endmodule

/* sv/trl_teid_calc.sv */
// ----------------------------------------------------------------------------
// trl_teid_calc
// Tunnel ID arithmetic: offset times step in one stage, plus the initial ID
// in the next, into the result register.
// ----------------------------------------------------------------------------
module trl_teid_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trl_pkg::match_t               match_i,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [trl_pkg::SLOT_W-1:0]    out_group_slot,
  output logic [trl_pkg::ID_W-1:0]      out_tunnel_id,
  output logic [trl_pkg::STAT_W-1:0]    out_status
);

  logic                         p_vld_r;
  logic                         p_hit_r;
  logic [trl_pkg::SLOT_W-1:0]   p_slot_r;
  logic [trl_pkg::STAT_W-1:0]   p_status_r;
  logic [trl_pkg::ID_W-1:0]     p_first_r;
  logic [trl_pkg::ID_W-1:0]     p_prod_r;
  logic [trl_pkg::ID_W-1:0]     p_prod_nxt;

  logic                         o_vld_r;
  logic                         o_hit_r;
  logic [trl_pkg::SLOT_W-1:0]   o_slot_r;
  logic [trl_pkg::STAT_W-1:0]   o_status_r;
  logic [trl_pkg::ID_W-1:0]     o_tid_r;
  logic [trl_pkg::ID_W-1:0]     o_tid_nxt;

  // Low word of the product is all the modulo arithmetic needs
  assign p_prod_nxt = match_i.offset * match_i.step;

  // Zero the ID for anything but a hit
  assign o_tid_nxt = p_hit_r ? (p_first_r + p_prod_r) : '0;

  // Advance the strobes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= match_i.vld;
      o_vld_r <= p_vld_r;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    p_hit_r    <= match_i.hit;
    p_slot_r   <= match_i.slot;
    p_status_r <= match_i.status;
    p_first_r  <= match_i.first;
    p_prod_r   <= p_prod_nxt;
  end

  // Result stage
  always_ff @(posedge clk) begin
    o_hit_r    <= p_hit_r;
    o_slot_r   <= p_slot_r;
    o_status_r <= p_status_r;
    o_tid_r    <= o_tid_nxt;
  end

  assign out_valid      = o_vld_r;
  assign out_hit        = o_hit_r;
  assign out_group_slot = o_slot_r;
  assign out_tunnel_id  = o_tid_r;
  assign out_status     = o_status_r;

endmodule

/* tb/sv/tb_tunnel_range_lookup_teid.sv */
// ----------------------------------------------------------------------------
// tb_tunnel_range_lookup_teid
// Self-checking bench for the tunnel range lookup table. A directed opening
// hits the address and ID extremes, the rejection rules and the unused
// operation code. A long random phase follows: mostly well-formed writes into
// sixteen address segments, lookups aimed at range edges, and some noise.
// A scoreboard keeps its own copy of the table and checks every result in
// order.
// ----------------------------------------------------------------------------
module tb_tunnel_range_lookup_teid;
  timeunit 1ns;
  timeprecision 1ps;
  import trl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1300;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ID_W-1:0]   first;
    logic [ID_W-1:0]   step;
  } range_item_t;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   tid;
    logic [STAT_W-1:0] status;
  } range_result_t;

  // Shadow range table and the queue of tunnel ID results still owed
  class range_table_checker;
    bit                slot_valid[GROUPS];
    logic [ADDR_W-1:0] slot_lo[GROUPS];
    logic [ADDR_W-1:0] slot_hi[GROUPS];
    logic [ID_W-1:0]   slot_first[GROUPS];
    logic [ID_W-1:0]   slot_step[GROUPS];
    range_result_t     pending_results[$];
    int errors;
    int n_clear;
    int n_write_ok;
    int n_order;
    int n_overlap;
    int n_hit;
    int n_miss;

    // Apply one accepted item to the shadow table and queue its result
    function void note_item(range_item_t it);
      range_result_t r;
      bit            clash;
      r = '{hit: 1'b0, slot: '0, tid: '0, status: ST_OK};
      clash = 1'b0;
      case (it.op)
        OP_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          n_clear++;
        end
        OP_WRITE: begin
          if (it.lo > it.hi) begin
            r.status = ST_ORDER;
            n_order++;
          end else if (int'(it.slot) < GROUPS) begin
            // Skip the slot being replaced when looking for shared addresses
            for (int i = 0; i < GROUPS; i++) begin
              if (i != int'(it.slot) && slot_valid[i] &&
                  it.lo <= slot_hi[i] && slot_lo[i] <= it.hi)
                clash = 1'b1;
            end
            if (clash) begin
              r.status = ST_OVERLAP;
              n_overlap++;
            end else begin
              slot_valid[it.slot] = 1'b1;
              slot_lo[it.slot]    = it.lo;
              slot_hi[it.slot]    = it.hi;
              slot_first[it.slot] = it.first;
              slot_step[it.slot]  = it.step;
              n_write_ok++;
            end
          end
        end
        OP_LOOKUP: begin
          r.status = ST_MISS;
          for (int i = 0; i < GROUPS; i++) begin
            if (!r.hit && slot_valid[i] && slot_lo[i] <= it.addr && it.addr <= slot_hi[i]) begin
              r.hit    = 1'b1;
              r.slot   = SLOT_W'(i);
              r.tid    = slot_first[i] + (it.addr - slot_lo[i]) * slot_step[i];
              r.status = ST_OK;
            end
          end
          if (r.hit) n_hit++;
          else n_miss++;
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Match one result against the oldest one owed
    function void check_result(range_result_t got);
      range_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual hit=%0b slot=%0d id=%h st=%0d",
                 $time, got.hit, got.slot, got.tid, got.status);
        return;
      end
      want = pending_results.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("group_slot", 32'(want.slot), 32'(got.slot));
      compare_field("tunnel_id", want.tid, got.tid);
      compare_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic              clk;
  logic              rst_n             = 1'b0;
  logic              start             = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation      = '0;
  logic [SLOT_W-1:0] in_entry_slot     = '0;
  logic [ADDR_W-1:0] in_lookup_address = '0;
  logic [ADDR_W-1:0] in_range_start    = '0;
  logic [ADDR_W-1:0] in_range_end      = '0;
  logic [ID_W-1:0]   in_initial_teid   = '0;
  logic [ID_W-1:0]   in_teid_step      = '0;
  logic              out_valid;
  logic              out_hit;
  logic [SLOT_W-1:0] out_group_slot;
  logic [ID_W-1:0]   out_tunnel_id;
  logic [STAT_W-1:0] out_status;

  range_table_checker lookup_chk = new;
  int                 gap_max = 0;

  tunnel_range_lookup_teid uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_entry_slot    (in_entry_slot),
    .in_lookup_address(in_lookup_address),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .in_initial_teid  (in_initial_teid),
    .in_teid_step     (in_teid_step),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_group_slot   (out_group_slot),
    .out_tunnel_id    (out_tunnel_id),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Check every result in the cycle it is strobed
  always @(posedge clk) begin : result_monitor
    range_result_t seen;
    if (out_valid === 1'b1) begin
      seen = '{hit: out_hit, slot: out_group_slot, tid: out_tunnel_id, status: out_status};
      lookup_chk.check_result(seen);
    end
  end

  function automatic range_item_t rand_item(logic [OP_W-1:0] op);
    range_item_t it;
    it.op    = op;
    it.slot  = SLOT_W'($urandom);
    it.addr  = $urandom;
    it.lo    = $urandom;
    it.hi    = $urandom;
    it.first = $urandom;
    it.step  = $urandom;
    return it;
  endfunction

  // Idle a random number of cycles, present the item, hold it until accepted
  task automatic send_item(range_item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= it.op;
    in_entry_slot     <= it.slot;
    in_lookup_address <= it.addr;
    in_range_start    <= it.lo;
    in_range_end      <= it.hi;
    in_initial_teid   <= it.first;
    in_teid_step      <= it.step;
    do @(posedge clk); while (busy);
    lookup_chk.note_item(it);
  endtask

  task automatic do_write(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] lo,
                          logic [ADDR_W-1:0] hi, logic [ID_W-1:0] first,
                          logic [ID_W-1:0] step);
    range_item_t it;
    it       = rand_item(OP_WRITE);
    it.slot  = slot;
    it.lo    = lo;
    it.hi    = hi;
    it.first = first;
    it.step  = step;
    send_item(it);
  endtask

  task automatic do_lookup(logic [ADDR_W-1:0] addr);
    range_item_t it;
    it      = rand_item(OP_LOOKUP);
    it.addr = addr;
    send_item(it);
  endtask

  // Send an operation with every payload field set to one value
  task automatic do_fill(logic [OP_W-1:0] op, logic [31:0] fill);
    range_item_t it;
    it = '{op: op, slot: SLOT_W'(fill), addr: fill, lo: fill, hi: fill,
           first: fill, step: fill};
    send_item(it);
  endtask

  initial begin
    range_item_t it;
    int          counted;
    int          pick;
    int          sel;
    int          wait_cycles;
    int          targets[$];
    logic [3:0]  seg;
    logic [27:0] a28;
    logic [27:0] b28;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] span;

    // Hold reset at the start, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, rejection order, self-replace, clear
    gap_max = 3;
    do_lookup(32'h0000_0000);
    do_fill(OP_UNUSED, '1);
    do_write(4'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0001);
    do_write(4'd5, 32'h0000_000A, 32'h0000_0005, 32'h0, 32'h0);
    do_write(4'd6, 32'h0000_0000, 32'h0000_0064, 32'h1, 32'h1);
    do_write(4'd7, 32'h0000_00C8, 32'h0000_0000, 32'h1, 32'h1);
    do_write(4'd0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    do_write(4'd1, 32'h8000_0000, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555);
    do_lookup(32'h0000_0000);
    do_lookup(32'h7FFF_FFFF);
    do_lookup(32'h8000_0000);
    do_lookup(32'hFFFF_FFFE);
    do_lookup(32'hFFFF_FFFF);
    do_write(4'd2, 32'h0000_0005, 32'h0000_0005, 32'h0, 32'h0);
    do_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    do_fill(OP_CLEAR, 32'hFFFF_FFFF);
    do_lookup(32'hFFFF_FFFF);
    do_lookup(32'h8000_0000);
    do_write(4'd3, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h9E37_79B9);
    do_lookup(32'hDEAD_BEEF);
    do_write(4'd4, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0);
    do_fill(OP_UNUSED, '0);
    do_lookup(32'h1234_5678);
    do_fill(OP_CLEAR, '0);

    // Random: bursts of table traffic, each with its own idling pattern
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      if ($urandom_range(0, 3) == 0) begin
        do_fill(OP_CLEAR, $urandom);
        counted++;
      end
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(0, 99);
        it   = rand_item(OP_LOOKUP);
        if (pick < 30) begin
          // Well-formed range inside one 256M segment
          it.op = OP_WRITE;
          seg   = 4'($urandom);
          a28   = 28'($urandom);
          b28   = ($urandom_range(0, 7) == 0) ? a28 : 28'($urandom);
          it.lo = {seg, (a28 < b28) ? a28 : b28};
          it.hi = {seg, (a28 < b28) ? b28 : a28};
          case ($urandom_range(0, 7))
            0:       it.step = '0;
            1:       it.step = 32'd1;
            2:       it.step = '1;
            default: ;
          endcase
        end else if (pick < 35) begin
          // Start after end
          it.op = OP_WRITE;
          a     = $urandom;
          b     = $urandom;
          it.lo = (a > b) ? a : b;
          it.hi = (a > b) ? b : a;
          if (a == b) begin
            it.lo = '1;
            it.hi = '0;
          end
        end else if (pick < 38) begin
          // Wide range, mostly colliding with the table
          it.op = OP_WRITE;
          a     = $urandom;
          b     = $urandom;
          it.lo = (a < b) ? a : b;
          it.hi = (a < b) ? b : a;
        end else if (pick < 40) begin
          it.op = OP_UNUSED;
        end else if (pick < 42) begin
          it.op = OP_CLEAR;
        end else begin
          // Aim most lookups at a live range, edges included
          targets.delete();
          foreach (lookup_chk.slot_valid[i])
            if (lookup_chk.slot_valid[i]) targets.insert(targets.size(), i);
          if (targets.size() > 0 && $urandom_range(0, 9) < 7) begin
            sel = targets[$urandom_range(0, targets.size() - 1)];
            case ($urandom_range(0, 4))
              0: it.addr = lookup_chk.slot_lo[sel];
              1: it.addr = lookup_chk.slot_hi[sel];
              2: it.addr = lookup_chk.slot_lo[sel] - 32'd1;
              3: it.addr = lookup_chk.slot_hi[sel] + 32'd1;
              default: begin
                span    = {32'h0, lookup_chk.slot_hi[sel] - lookup_chk.slot_lo[sel]} + 64'd1;
                it.addr = lookup_chk.slot_lo[sel] + 32'({32'h0, $urandom} % span);
              end
            endcase
          end
        end
        send_item(it);
        if (it.op != OP_UNUSED) counted++;
      end
    end
    start <= 1'b0;

    // Drain the pipeline
    wait_cycles = 0;
    while (lookup_chk.pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lookup_chk.pending_results.size() != 0) begin
      lookup_chk.errors++;
      $display("%0t: results never arrived: expected 0 outstanding, actual %0d",
               $time, lookup_chk.pending_results.size());
    end

    $display("Run covered %0d clears, %0d stored writes, %0d start-after-end%s",
             lookup_chk.n_clear, lookup_chk.n_write_ok, lookup_chk.n_order, " rejects,");
    $display("%0d overlap rejects, %0d lookup hits against %0d misses; %0d mismatches.",
             lookup_chk.n_overlap, lookup_chk.n_hit, lookup_chk.n_miss, lookup_chk.errors);
    if (lookup_chk.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
